@@ rtl/core/bfsp_pkg.sv @@
// Shared types and constants for the shortest-path search block.
// No dependencies; every other file in rtl/core imports this package.
package bfsp_pkg;

    localparam int NODE_W     = 6;
    localparam int NODE_SLOTS = 64;
    localparam int RESULT_CAP = 64;
    localparam int DIST_W     = 32;
    localparam int WEIGHT_W   = 16;
    localparam int NCNT_W     = 7;

    // Item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_START_NODE = 2'd1;
    localparam logic [1:0] CFG_END_NODE   = 2'd2;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_NONE   = 2'd1,
        ST_NEGCYC = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [NODE_W-1:0]          edge_src;
        logic [NODE_W-1:0]          edge_dst;
        logic signed [WEIGHT_W-1:0] edge_weight;
    } t_item;

    typedef struct packed {
        logic [NODE_W-1:0]        path_node;
        logic signed [DIST_W-1:0] end_distance;
        t_status                  status;
        logic                     last;
    } t_result;

    typedef struct packed {
        logic [NODE_W-1:0]          src;
        logic [NODE_W-1:0]          dst;
        logic signed [WEIGHT_W-1:0] weight;
    } t_edge;

    typedef struct packed {
        logic                     dvalid;
        logic                     pvalid;
        logic signed [DIST_W-1:0] distance;
        logic [NODE_W-1:0]        pred;
    } t_node_entry;

    typedef struct packed {
        logic [NODE_W-1:0] addr_a;
        logic [NODE_W-1:0] addr_b;
    } t_node_rd;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        t_node_entry       data;
    } t_node_wr;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_INIT,
        S_ERD,
        S_NRD,
        S_EVAL,
        S_WRD,
        S_WCHK,
        S_EMIT,
        S_SINGLE
    } t_seq_state;

endpackage

@@ rtl/core/bfsp_edge_store.sv @@
// Edge list storage: append-only memory with a fill count, cleared by count reset.
// Depends on bfsp_pkg for the edge record type.
module bfsp_edge_store #(
    parameter int MAX_EDGES = 256,
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int CW = $clog2(MAX_EDGES + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_clear,
    input  bfsp_pkg::t_edge i_edge,
    input  logic [EW-1:0]  i_raddr,
    output bfsp_pkg::t_edge o_rdata,
    output logic [CW-1:0]  o_count
);
    import bfsp_pkg::*;

    t_edge         mem [MAX_EDGES];
    t_edge         r_rdata;
    logic [CW-1:0] r_count;
    logic          wr_en;

    // Drop loads once the list is full
    assign wr_en = i_load && (r_count < CW'(MAX_EDGES));

    // Track the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clear) begin
            r_count <= '0;
        end else if (wr_en) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Write at the fill count, read registered
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[EW-1:0]] <= i_edge;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

endmodule

@@ rtl/core/bfsp_node_store.sv @@
// Per-node distance and predecessor memory: two registered read ports, one write.
// Depends on bfsp_pkg for the node entry and port structs.
module bfsp_node_store (
    input  logic                  i_clk,
    input  bfsp_pkg::t_node_rd    i_rd,
    input  bfsp_pkg::t_node_wr    i_wr,
    output bfsp_pkg::t_node_entry o_qa,
    output bfsp_pkg::t_node_entry o_qb
);
    import bfsp_pkg::*;

    t_node_entry mem [NODE_SLOTS];
    t_node_entry r_qa;
    t_node_entry r_qb;

    // Write one entry, read two
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_qa <= mem[i_rd.addr_a];
        r_qb <= mem[i_rd.addr_b];
    end

    assign o_qa = r_qa;
    assign o_qb = r_qb;

endmodule

@@ rtl/core/bfsp_relax.sv @@
// Shared relaxation unit: saturating distance-plus-weight and strict less-than test.
// Depends on bfsp_pkg for the node entry type and distance limits.
module bfsp_relax (
    input  bfsp_pkg::t_node_entry i_u,
    input  bfsp_pkg::t_node_entry i_v,
    input  logic signed [15:0]    i_weight,
    input  logic                  i_in_range,
    output logic                  o_improve,
    output logic signed [31:0]    o_cand
);
    import bfsp_pkg::*;

    logic signed [DIST_W:0] sum;

    // Add in 33 bits, then clamp to the 32-bit range
    assign sum = {i_u.distance[DIST_W-1], i_u.distance}
               + {{(DIST_W + 1 - WEIGHT_W){i_weight[WEIGHT_W-1]}}, i_weight};

    always_comb begin
        if (sum[DIST_W] != sum[DIST_W-1]) begin
            o_cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
        end else begin
            o_cand = sum[DIST_W-1:0];
        end
    end

    // Improve when the edge is in range, the source is reached and the target is unreached or farther
    assign o_improve = i_in_range && i_u.dvalid
                       && (!i_v.dvalid || (o_cand < i_v.distance));

endmodule

@@ rtl/core/bfsp_seq.sv @@
// Search sequencer: node clear, relaxation passes, negative-cycle pass, path walk
// and result emission with its path buffer. Depends on bfsp_pkg.
module bfsp_seq #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256,
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int CW = $clog2(MAX_EDGES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_run,
    input  logic [6:0]            i_node_count,
    input  logic [5:0]            i_start_node,
    input  logic [5:0]            i_end_node,
    input  logic [CW-1:0]         i_edge_count,
    input  bfsp_pkg::t_edge       i_edge,
    output logic [EW-1:0]         o_edge_raddr,
    output bfsp_pkg::t_node_rd    o_node_rd,
    output bfsp_pkg::t_node_wr    o_node_wr,
    input  bfsp_pkg::t_node_entry i_qa,
    output logic                  o_in_range,
    input  logic                  i_improve,
    input  logic signed [31:0]    i_cand,
    output logic                  o_busy,
    output logic                  o_strobe,
    output bfsp_pkg::t_result     o_result
);
    import bfsp_pkg::*;

    localparam logic [NCNT_W-1:0] N_LIMIT = NCNT_W'((MAX_NODES < 127) ? MAX_NODES : 127);

    t_seq_state r_state;
    t_seq_state n_state;

    logic [NCNT_W-1:0] r_n;
    logic [NODE_W-1:0] r_s;
    logic [NODE_W-1:0] r_t;
    logic [CW-1:0]     r_e;
    logic [NCNT_W-1:0] r_pass;
    logic              r_chk;
    logic [NODE_W-1:0] r_clr;
    logic [NODE_W-1:0] r_at;
    logic [NCNT_W-1:0] r_len;
    logic [DIST_W-1:0] r_dist;
    logic [NODE_W-1:0] r_emit_idx;
    t_status           r_sstat;

    logic [NODE_W-1:0] pbuf [RESULT_CAP];
    logic [NODE_W-1:0] r_pb_q;
    logic              pb_we;

    logic              r_out_valid;
    logic              r_out_last;
    logic              r_out_single;
    t_status           r_out_status;
    logic [DIST_W-1:0] r_out_dist;

    logic [NCNT_W-1:0] n_clamped;
    logic              last_edge;
    logic              end_outside;
    logic              walk_unreached;
    logic              walk_overrun;

    // Clamp the node count to 1..MAX_NODES, and to at most 127
    always_comb begin
        if (i_node_count == '0) begin
            n_clamped = NCNT_W'(1);
        end else if (i_node_count > N_LIMIT) begin
            n_clamped = N_LIMIT;
        end else begin
            n_clamped = i_node_count;
        end
    end

    assign last_edge      = (CW'(r_e + 1'b1) == i_edge_count);
    assign end_outside    = ({1'b0, r_t} >= r_n);
    assign walk_unreached = (r_len == '0) && !i_qa.dvalid;
    assign walk_overrun   = (r_len >= r_n) || (r_len == NCNT_W'(RESULT_CAP));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_run) n_state = S_CLEAR;
            end
            S_CLEAR: begin
                if (r_clr == NODE_W'(NODE_SLOTS - 1)) n_state = S_INIT;
            end
            S_INIT: begin
                if (i_edge_count != '0) n_state = S_ERD;
                else if (end_outside)   n_state = S_SINGLE;
                else                    n_state = S_WRD;
            end
            S_ERD:  n_state = S_NRD;
            S_NRD:  n_state = S_EVAL;
            S_EVAL: begin
                if (r_chk && i_improve) begin
                    n_state = S_SINGLE;
                end else if (r_chk && last_edge) begin
                    n_state = end_outside ? S_SINGLE : S_WRD;
                end else begin
                    n_state = S_ERD;
                end
            end
            S_WRD:  n_state = S_WCHK;
            S_WCHK: begin
                if (walk_unreached || walk_overrun) n_state = S_SINGLE;
                else if (!i_qa.pvalid)              n_state = S_EMIT;
                else                                n_state = S_WRD;
            end
            S_EMIT: begin
                if (r_emit_idx == '0) n_state = S_IDLE;
            end
            S_SINGLE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Memory controls per state
    always_comb begin
        o_node_rd.addr_a = (r_state == S_WRD) ? r_at : i_edge.src;
        o_node_rd.addr_b = i_edge.dst;
        o_node_wr        = '0;
        pb_we            = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_node_wr.en   = 1'b1;
                o_node_wr.addr = r_clr;
            end
            S_INIT: begin
                o_node_wr.en          = ({1'b0, r_s} < r_n);
                o_node_wr.addr        = r_s;
                o_node_wr.data.dvalid = 1'b1;
            end
            S_EVAL: begin
                o_node_wr.en            = !r_chk && i_improve;
                o_node_wr.addr          = i_edge.dst;
                o_node_wr.data.dvalid   = 1'b1;
                o_node_wr.data.pvalid   = 1'b1;
                o_node_wr.data.distance = i_cand;
                o_node_wr.data.pred     = i_edge.src;
            end
            S_WCHK: begin
                pb_we = !walk_unreached && !walk_overrun;
            end
            default: begin
                o_node_wr = '0;
            end
        endcase
    end

    assign o_in_range   = ({1'b0, i_edge.src} < r_n) && ({1'b0, i_edge.dst} < r_n);
    assign o_edge_raddr = r_e[EW-1:0];
    assign o_busy       = (r_state != S_IDLE);

    // Advance state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_EMIT) || (r_state == S_SINGLE);
        end
    end

    // Counters and run registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_run) begin
                    r_n   <= n_clamped;
                    r_s   <= i_start_node;
                    r_t   <= i_end_node;
                    r_clr <= '0;
                end
            end
            S_CLEAR: begin
                r_clr <= r_clr + 1'b1;
            end
            S_INIT: begin
                r_e     <= '0;
                r_pass  <= '0;
                r_chk   <= (r_n == NCNT_W'(1));
                r_at    <= r_t;
                r_len   <= '0;
                r_sstat <= ST_NONE;
            end
            S_EVAL: begin
                if (r_chk && i_improve) begin
                    r_sstat <= ST_NEGCYC;
                end else if (last_edge) begin
                    r_e    <= '0;
                    r_pass <= r_pass + 1'b1;
                    if (!r_chk && (r_pass == r_n - NCNT_W'(2))) r_chk <= 1'b1;
                end else begin
                    r_e <= r_e + 1'b1;
                end
            end
            S_WCHK: begin
                if (walk_unreached) begin
                    r_sstat <= ST_NONE;
                end else if (walk_overrun) begin
                    r_sstat <= ST_NEGCYC;
                end else begin
                    r_len      <= r_len + 1'b1;
                    r_emit_idx <= r_len[NODE_W-1:0];
                    r_at       <= i_qa.pred;
                    if (r_len == '0) r_dist <= i_qa.distance;
                end
            end
            S_EMIT: begin
                r_emit_idx <= r_emit_idx - 1'b1;
            end
            default: begin
                r_e <= r_e;
            end
        endcase
    end

    // Path buffer: write during the walk, read back start first
    always_ff @(posedge i_clk) begin
        if (pb_we) begin
            pbuf[r_len[NODE_W-1:0]] <= r_at;
        end
        r_pb_q <= pbuf[r_emit_idx];
    end

    // Hold result payload for its strobe cycle
    always_ff @(posedge i_clk) begin
        r_out_last   <= (r_state == S_SINGLE) || (r_emit_idx == '0);
        r_out_single <= (r_state == S_SINGLE);
        r_out_status <= (r_state == S_SINGLE) ? r_sstat : ST_FOUND;
        r_out_dist   <= r_dist;
    end

    assign o_strobe              = r_out_valid;
    assign o_result.path_node    = r_out_single ? r_t : r_pb_q;
    assign o_result.end_distance = r_out_single ? '0 : r_out_dist;
    assign o_result.status       = r_out_status;
    assign o_result.last         = r_out_last;

    // A result only follows an emission state
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == S_EMIT || r_state == S_SINGLE))
        else $error("result strobe without emission state");

    // Node memory is written only when clearing, seeding or relaxing
    a_node_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_node_wr.en |-> (r_state == S_CLEAR || r_state == S_INIT
                          || (r_state == S_EVAL && !r_chk)))
        else $error("node write outside relaxation");

    // Path length stays within the buffer
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRD || r_state == S_WCHK) |-> (r_len <= NCNT_W'(RESULT_CAP)))
        else $error("path length overrun");

    // A single status result is always the final one
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_single) |-> (r_out_last && r_out_status != ST_FOUND))
        else $error("single result not marked last");

endmodule

@@ rtl/core/bellman_ford_shortest_path.sv @@
// Single-source shortest path search over a loaded edge list; results cannot be stalled.
// Load and clear transactions are accepted while busy is low and leave it low, so they run back to back.
// A run holds busy while it clears all 64 node slots, seeds the start node, runs the N-1
// relaxation passes and the check pass (which stops at its first improving edge), walks the
// path and emits the results; each strobe is registered from its emission state.
// Synchronous active-low reset empties the edge list and restores the configuration registers and the sequencer state.
module bellman_ford_shortest_path #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bfsp_pkg::t_item   i_item,
    output logic              o_result_strobe,
    output bfsp_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [6:0]        i_cfg_data
);
    import bfsp_pkg::*;

    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);

    logic [6:0]        r_node_count;
    logic [5:0]        r_start_node;
    logic [5:0]        r_end_node;

    logic              accept;
    logic              load;
    logic              clear;
    logic              run;
    t_edge             new_edge;
    t_edge             edge_q;
    logic [EW-1:0]     edge_raddr;
    logic [CW-1:0]     edge_count;
    t_node_rd          node_rd;
    t_node_wr          node_wr;
    t_node_entry       qa;
    t_node_entry       qb;
    logic              in_range;
    logic              improve;
    logic signed [31:0] cand;

    assign accept = start && !busy;
    assign load   = accept && (i_item.kind == KIND_LOAD);
    assign clear  = accept && (i_item.kind == KIND_CLEAR);
    assign run    = accept && (i_item.kind == KIND_RUN);

    assign new_edge.src    = i_item.edge_src;
    assign new_edge.dst    = i_item.edge_dst;
    assign new_edge.weight = i_item.edge_weight;

    // Configuration write transaction
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 7'd64;
            r_start_node <= '0;
            r_end_node   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                CFG_START_NODE: r_start_node <= i_cfg_data[5:0];
                CFG_END_NODE:   r_end_node   <= i_cfg_data[5:0];
                default:        r_node_count <= r_node_count;
            endcase
        end
    end

    bfsp_edge_store #(
        .MAX_EDGES (MAX_EDGES)
    ) u_edge_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_clear (clear),
        .i_edge  (new_edge),
        .i_raddr (edge_raddr),
        .o_rdata (edge_q),
        .o_count (edge_count)
    );

    bfsp_node_store u_node_store (
        .i_clk (i_clk),
        .i_rd  (node_rd),
        .i_wr  (node_wr),
        .o_qa  (qa),
        .o_qb  (qb)
    );

    bfsp_relax u_relax (
        .i_u        (qa),
        .i_v        (qb),
        .i_weight   (edge_q.weight),
        .i_in_range (in_range),
        .o_improve  (improve),
        .o_cand     (cand)
    );

    bfsp_seq #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_run        (run),
        .i_node_count (r_node_count),
        .i_start_node (r_start_node),
        .i_end_node   (r_end_node),
        .i_edge_count (edge_count),
        .i_edge       (edge_q),
        .o_edge_raddr (edge_raddr),
        .o_node_rd    (node_rd),
        .o_node_wr    (node_wr),
        .i_qa         (qa),
        .o_in_range   (in_range),
        .i_improve    (improve),
        .i_cand       (cand),
        .o_busy       (busy),
        .o_strobe     (o_result_strobe),
        .o_result     (o_result)
    );

endmodule
